[rtl/core/ttcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_pkg
// shared widths, codes and types of the terminal cursor buffer
// ----------------------------------------------------------------------------
package ttcb_pkg;

   // default geometry
   localparam int MAX_COLS_DEF   = 128;
   localparam int MAX_ROWS_DEF   = 64;
   localparam int STYLE_BITS_DEF = 16;

   // channel field widths
   localparam int ACTION_W  = 2;
   localparam int CH_W      = 21;
   localparam int STYLE_W   = 16;
   localparam int RCOL_W    = 7;
   localparam int RROW_W    = 6;
   localparam int CCOL_W    = 7;
   localparam int CROW_W    = 6;

   // register widths
   localparam int COLS_W    = 8;
   localparam int ROWS_W    = 7;
   localparam int TAB_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // effective grid size, wide enough for the whole geometry range
   localparam int EFF_COLS_W = 9;
   localparam int EFF_ROWS_W = 8;

   // actions
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK = 2'd3;

   // register reset values
   localparam logic [COLS_W-1:0]  COLS_RST  = 8'd80;
   localparam logic [ROWS_W-1:0]  ROWS_RST  = 7'd25;
   localparam logic [TAB_W-1:0]   TAB_RST   = 5'd8;
   localparam logic [STYLE_W-1:0] BLANK_RST = 16'd0;

   // character codes
   localparam logic [CH_W-1:0] CH_BS    = 21'd8;
   localparam logic [CH_W-1:0] CH_TAB   = 21'd9;
   localparam logic [CH_W-1:0] CH_LF    = 21'd10;
   localparam logic [CH_W-1:0] CH_VT    = 21'd11;
   localparam logic [CH_W-1:0] CH_CR    = 21'd13;
   localparam logic [CH_W-1:0] CH_SPACE = 21'd32;
   localparam logic [CH_W-1:0] CH_DEL   = 21'd127;

   typedef struct packed {
      logic [EFF_COLS_W-1:0] cols_eff;
      logic [EFF_ROWS_W-1:0] rows_eff;
      logic [TAB_W-1:0]      tab;
      logic [STYLE_W-1:0]    blank_style;
   } cfg_type;

   typedef struct packed {
      logic [CCOL_W-1:0]  cursor_col;
      logic [CROW_W-1:0]  cursor_row;
      logic [CH_W-1:0]    read_char;
      logic [STYLE_W-1:0] read_style;
      logic               scrolled;
   } rsp_type;

endpackage

[rtl/core/ttcb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface ttcb_req_if;
   logic                          valid;
   logic                          ready;
   logic [ttcb_pkg::ACTION_W-1:0] action;
   logic [ttcb_pkg::CH_W-1:0]     ch;
   logic [ttcb_pkg::STYLE_W-1:0]  style;
   logic [ttcb_pkg::RCOL_W-1:0]   read_col;
   logic [ttcb_pkg::RROW_W-1:0]   read_row;

   modport source (output valid, action, ch, style, read_col, read_row, input ready);
   modport sink   (input valid, action, ch, style, read_col, read_row, output ready);
endinterface

interface ttcb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ttcb_pkg::CCOL_W-1:0]  cursor_col;
   logic [ttcb_pkg::CROW_W-1:0]  cursor_row;
   logic [ttcb_pkg::CH_W-1:0]    read_char;
   logic [ttcb_pkg::STYLE_W-1:0] read_style;
   logic                         scrolled;

   modport source (output valid, cursor_col, cursor_row, read_char, read_style, scrolled,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, read_char, read_style, scrolled,
                   output ready);
endinterface

interface ttcb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ttcb_pkg::CSR_IDX_W-1:0] index;
   logic [ttcb_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ttcb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ttcb_ram #(
   parameter int WIDTH = 37,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ttcb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcb_ctrl
// item sequencer: cursor, scroll offset, cell store access and row sweeps
// ----------------------------------------------------------------------------
module ttcb_ctrl #(
   parameter int MAX_COLS   = ttcb_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = ttcb_pkg::MAX_ROWS_DEF,
   parameter int STYLE_BITS = ttcb_pkg::STYLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ttcb_req_if.sink              req_chan,
   ttcb_rsp_if.source            rsp_chan,
   input  ttcb_pkg::cfg_type     cfg,
   output logic                  ram_wr_en,
   output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] ram_wr_addr,
   output logic [ttcb_pkg::CH_W+STYLE_BITS-1:0] ram_wr_data,
   output logic                  ram_rd_en,
   output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] ram_rd_addr,
   input  logic [ttcb_pkg::CH_W+STYLE_BITS-1:0] ram_rd_data
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = ttcb_pkg::EFF_COLS_W + 5;
   localparam int YW    = ttcb_pkg::EFF_ROWS_W + 1;
   localparam int SW    = STYLE_BITS + ttcb_pkg::STYLE_W;

   localparam logic [RW:0]   ROWS_LIM  = (RW+1)'(MAX_ROWS);
   localparam logic [RW-1:0] TOP_LAST  = RW'(MAX_ROWS - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROW_SPAN  = AW'(MAX_COLS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WALK
   } state_type;

   // physical row is the logical row rotated by the scroll offset
   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
                                               input logic [RW-1:0] row,
                                               input logic [RW-1:0] top);
      logic [RW:0] phys;
      phys = {1'b0, row} + {1'b0, top};
      if (phys >= ROWS_LIM) begin
         phys = phys - ROWS_LIM;
      end
      return AW'(phys) * AW'(MAX_COLS) + AW'(col);
   endfunction

   function automatic logic [ttcb_pkg::CCOL_W-1:0] to_ccol(input logic [CW-1:0] v);
      logic [CW+ttcb_pkg::CCOL_W-1:0] t;
      t = {{ttcb_pkg::CCOL_W{1'b0}}, v};
      return t[ttcb_pkg::CCOL_W-1:0];
   endfunction

   function automatic logic [ttcb_pkg::CROW_W-1:0] to_crow(input logic [RW-1:0] v);
      logic [RW+ttcb_pkg::CROW_W-1:0] t;
      t = {{ttcb_pkg::CROW_W{1'b0}}, v};
      return t[ttcb_pkg::CROW_W-1:0];
   endfunction

   function automatic logic [CW-1:0] from_rcol(input logic [ttcb_pkg::RCOL_W-1:0] v);
      logic [CW+ttcb_pkg::RCOL_W-1:0] t;
      t = {{CW{1'b0}}, v};
      return t[CW-1:0];
   endfunction

   function automatic logic [RW-1:0] from_rrow(input logic [ttcb_pkg::RROW_W-1:0] v);
      logic [RW+ttcb_pkg::RROW_W-1:0] t;
      t = {{RW{1'b0}}, v};
      return t[RW-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [CW-1:0]         cur_col_ff, cur_col_in;
   logic [RW-1:0]         cur_row_ff, cur_row_in;
   logic [RW-1:0]         top_ff, top_in;
   logic [AW-1:0]         walk_addr_ff, walk_addr_in;
   logic [AW-1:0]         walk_last_ff, walk_last_in;
   logic [STYLE_BITS-1:0] walk_style_ff, walk_style_in;
   logic                  walk_reply_ff, walk_reply_in;
   logic                  walk_scroll_ff, walk_scroll_in;
   logic                  in_grid_ff, in_grid_in;
   logic                  res_valid_ff, res_valid_in;
   ttcb_pkg::rsp_type     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ttcb_pkg::rsp_type     rsp_ff, rsp_in;

   logic [ttcb_pkg::EFF_COLS_W-1:0] cols_m1;
   logic [ttcb_pkg::EFF_ROWS_W-1:0] rows_m1;
   logic [CW-1:0]         col_last, col_cl;
   logic [RW-1:0]         row_last, row_cl;
   logic [SW-1:0]         req_style_ext, blank_style_ext, rd_style_ext;
   logic [STYLE_BITS-1:0] req_style_st, blank_style_st;
   logic                  accept;
   logic [XW-1:0]         x, w;
   logic [YW-1:0]         y, h;
   logic                  place, scroll;
   logic [CW-1:0]         new_col;
   logic [RW-1:0]         new_row;
   logic [RW-1:0]         top_next;
   logic [AW-1:0]         put_addr, rd_addr, row_base;
   logic                  rd_in_grid;

   // grid bounds and cursor clamped into a possibly shrunk grid
   always_comb begin
      cols_m1  = cfg.cols_eff - ttcb_pkg::EFF_COLS_W'(1);
      rows_m1  = cfg.rows_eff - ttcb_pkg::EFF_ROWS_W'(1);
      col_last = cols_m1[CW-1:0];
      row_last = rows_m1[RW-1:0];
      col_cl   = (XW'(cur_col_ff) >= XW'(cfg.cols_eff)) ? col_last : cur_col_ff;
      row_cl   = (YW'(cur_row_ff) >= YW'(cfg.rows_eff)) ? row_last : cur_row_ff;
   end

   // style width adaptation
   always_comb begin
      req_style_ext   = {{STYLE_BITS{1'b0}}, req_chan.style};
      blank_style_ext = {{STYLE_BITS{1'b0}}, cfg.blank_style};
      rd_style_ext    = {{ttcb_pkg::STYLE_W{1'b0}}, ram_rd_data[STYLE_BITS-1:0]};
      req_style_st    = req_style_ext[STYLE_BITS-1:0];
      blank_style_st  = blank_style_ext[STYLE_BITS-1:0];
   end

   // next cursor for a put
   always_comb begin
      x      = XW'(col_cl);
      y      = YW'(row_cl);
      w      = XW'(cfg.cols_eff);
      h      = YW'(cfg.rows_eff);
      place  = 1'b0;
      scroll = 1'b0;
      if (req_chan.ch == ttcb_pkg::CH_BS) begin
         // backspace: wrap back one row, never scrolls
         if (x != '0) begin
            x = x - XW'(1);
         end else if (y != '0) begin
            x = w - XW'(1);
            y = y - YW'(1);
         end
      end else begin
         unique case (req_chan.ch)
            ttcb_pkg::CH_CR: begin
               x = '0;
            end
            ttcb_pkg::CH_LF: begin
               x = '0;
               y = y + YW'(1);
            end
            ttcb_pkg::CH_TAB: begin
               x = x + XW'(cfg.tab);
            end
            ttcb_pkg::CH_VT: begin
               y = y + YW'(1);
            end
            ttcb_pkg::CH_DEL: begin
            end
            default: begin
               place = 1'b1;
               x     = x + XW'(1);
            end
         endcase
         if (x >= w) begin
            x = '0;
            y = y + YW'(1);
         end
         if (y >= h) begin
            scroll = 1'b1;
            y      = y - YW'(1);
         end
      end
      new_col = x[CW-1:0];
      new_row = y[RW-1:0];
   end

   // store addresses
   always_comb begin
      top_next   = (top_ff == TOP_LAST) ? '0 : top_ff + RW'(1);
      put_addr   = cell_addr(col_cl, row_cl, top_ff);
      rd_addr    = cell_addr(from_rcol(req_chan.read_col), from_rrow(req_chan.read_row),
                             top_ff);
      row_base   = cell_addr('0, row_last, top_next);
      rd_in_grid = (ttcb_pkg::EFF_COLS_W'(req_chan.read_col) < cfg.cols_eff) &&
                   (ttcb_pkg::EFF_ROWS_W'(req_chan.read_row) < cfg.rows_eff);
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !res_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cur_col_in     = col_cl;
      cur_row_in     = row_cl;
      top_in         = top_ff;
      walk_addr_in   = walk_addr_ff;
      walk_last_in   = walk_last_ff;
      walk_style_in  = walk_style_ff;
      walk_reply_in  = walk_reply_ff;
      walk_scroll_in = walk_scroll_ff;
      in_grid_in     = in_grid_ff;
      res_valid_in   = res_valid_ff;
      res_in         = res_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = walk_addr_ff;
      ram_wr_data    = {ttcb_pkg::CH_SPACE, walk_style_ff};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_addr;

      // result stage to output register
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      if (res_valid_ff && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
         res_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in.cursor_col = to_ccol(col_cl);
               res_in.cursor_row = to_crow(row_cl);
               res_in.read_char  = '0;
               res_in.read_style = '0;
               res_in.scrolled   = 1'b0;
               case (req_chan.action)
                  ttcb_pkg::ACT_PUT: begin
                     if (place) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = put_addr;
                        ram_wr_data = {req_chan.ch, req_style_st};
                     end
                     cur_col_in        = new_col;
                     cur_row_in        = new_row;
                     res_in.cursor_col = to_ccol(new_col);
                     res_in.cursor_row = to_crow(new_row);
                     if (scroll) begin
                        // rotate up and blank the new bottom row
                        top_in         = top_next;
                        walk_addr_in   = row_base;
                        walk_last_in   = row_base + ROW_SPAN;
                        walk_style_in  = blank_style_st;
                        walk_reply_in  = 1'b1;
                        walk_scroll_in = 1'b1;
                        state_in       = ST_WALK;
                     end else begin
                        res_valid_in = 1'b1;
                     end
                  end
                  ttcb_pkg::ACT_READ: begin
                     ram_rd_en  = 1'b1;
                     in_grid_in = rd_in_grid;
                     state_in   = ST_READ;
                  end
                  ttcb_pkg::ACT_CLEAR: begin
                     // cursor goes home and the reply reports it there
                     cur_col_in        = '0;
                     cur_row_in        = '0;
                     res_in.cursor_col = '0;
                     res_in.cursor_row = '0;
                     top_in            = '0;
                     walk_addr_in      = '0;
                     walk_last_in      = ADDR_LAST;
                     walk_style_in     = blank_style_st;
                     walk_reply_in     = 1'b1;
                     walk_scroll_in    = 1'b0;
                     state_in          = ST_WALK;
                  end
                  default: begin
                     res_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_valid_in = 1'b1;
            if (in_grid_ff) begin
               res_in.read_char  = ram_rd_data[ttcb_pkg::CH_W+STYLE_BITS-1:STYLE_BITS];
               res_in.read_style = rd_style_ext[ttcb_pkg::STYLE_W-1:0];
            end else begin
               res_in.read_char  = ttcb_pkg::CH_SPACE;
               res_in.read_style = blank_style_ext[ttcb_pkg::STYLE_W-1:0];
            end
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            ram_wr_en    = 1'b1;
            walk_addr_in = walk_addr_ff + AW'(1);
            if (walk_addr_ff == walk_last_ff) begin
               state_in = ST_IDLE;
               if (walk_reply_ff) begin
                  res_valid_in    = 1'b1;
                  res_in.scrolled = walk_scroll_ff;
                  walk_reply_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_WALK;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         top_ff         <= '0;
         walk_addr_ff   <= '0;
         walk_last_ff   <= ADDR_LAST;
         walk_style_ff  <= '0;
         walk_reply_ff  <= 1'b0;
         walk_scroll_ff <= 1'b0;
         res_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         top_ff         <= top_in;
         walk_addr_ff   <= walk_addr_in;
         walk_last_ff   <= walk_last_in;
         walk_style_ff  <= walk_style_in;
         walk_reply_ff  <= walk_reply_in;
         walk_scroll_ff <= walk_scroll_in;
         res_valid_ff   <= res_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      in_grid_ff <= in_grid_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_col = rsp_ff.cursor_col;
   assign rsp_chan.cursor_row = rsp_ff.cursor_row;
   assign rsp_chan.read_char  = rsp_ff.read_char;
   assign rsp_chan.read_style = rsp_ff.read_style;
   assign rsp_chan.scrolled   = rsp_ff.scrolled;

   // checks
   default disable iff (reset);

   a_walk_in_range: assert property (@(posedge clock)
      state_ff == ST_WALK |-> walk_addr_ff <= walk_last_ff)
      else $error("sweep address past its end");

   a_top_in_range: assert property (@(posedge clock)
      top_ff <= TOP_LAST)
      else $error("scroll offset out of range");

   a_busy_no_result: assert property (@(posedge clock)
      state_ff != ST_IDLE |-> !res_valid_ff)
      else $error("result stage busy while an item is in flight");

   a_read_one_cycle: assert property (@(posedge clock)
      state_ff == ST_READ |=> state_ff == ST_IDLE && res_valid_ff)
      else $error("read result not captured after one cycle");

   a_scroll_bottom: assert property (@(posedge clock)
      res_valid_ff && res_ff.scrolled |-> res_ff.cursor_row == to_crow(row_last))
      else $error("scroll left cursor off the bottom row");

endmodule

[rtl/core/text_terminal_cursor_buffer.sv]
`timescale 1ns / 1ps
// replies: a put passes the result register, then the rsp output register; a read
//   waits in ST_READ for its ram read first; a scroll sweeps a row, a clear every cell
// throughput: req is not ready until the result register has emptied; the single write
//   port of the cell ram sets the scroll and clear cost at one cell per cycle
// reset: synchronous; a clearing pass over all MAX_COLS*MAX_ROWS cells (8192 by default)
//   blanks the store, req is not ready meanwhile, csr writes are taken throughout
// ----------------------------------------------------------------------------
// text_terminal_cursor_buffer
// text mode character grid with cursor, wrap, scroll and cell readback
// ----------------------------------------------------------------------------
module text_terminal_cursor_buffer #(
   parameter int MAX_COLS   = ttcb_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS   = ttcb_pkg::MAX_ROWS_DEF,
   parameter int STYLE_BITS = ttcb_pkg::STYLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ttcb_req_if.sink   req_chan,
   ttcb_rsp_if.source rsp_chan,
   ttcb_csr_if.sink   csr_chan
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = ttcb_pkg::CH_W + STYLE_BITS;

   // grid size limits in the width of the effective size
   localparam logic [ttcb_pkg::EFF_COLS_W-1:0] COLS_MAX = ttcb_pkg::EFF_COLS_W'(MAX_COLS);
   localparam logic [ttcb_pkg::EFF_ROWS_W-1:0] ROWS_MAX = ttcb_pkg::EFF_ROWS_W'(MAX_ROWS);

   // configuration registers
   logic [ttcb_pkg::COLS_W-1:0]  cols_ff, cols_in;
   logic [ttcb_pkg::ROWS_W-1:0]  rows_ff, rows_in;
   logic [ttcb_pkg::TAB_W-1:0]   tab_ff, tab_in;
   logic [ttcb_pkg::STYLE_W-1:0] blank_ff, blank_in;

   ttcb_pkg::cfg_type cfg;

   // cell ram port signals
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [DW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [DW-1:0] ram_rd_data;

   // registers are always writable, one transfer per cycle
   assign csr_chan.ready = 1'b1;

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      tab_in   = tab_ff;
      blank_in = blank_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ttcb_pkg::CSR_COLS:  cols_in  = csr_chan.data[ttcb_pkg::COLS_W-1:0];
            ttcb_pkg::CSR_ROWS:  rows_in  = csr_chan.data[ttcb_pkg::ROWS_W-1:0];
            ttcb_pkg::CSR_TAB:   tab_in   = csr_chan.data[ttcb_pkg::TAB_W-1:0];
            ttcb_pkg::CSR_BLANK: blank_in = csr_chan.data[ttcb_pkg::STYLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= ttcb_pkg::COLS_RST;
         rows_ff  <= ttcb_pkg::ROWS_RST;
         tab_ff   <= ttcb_pkg::TAB_RST;
         blank_ff <= ttcb_pkg::BLANK_RST;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         tab_ff   <= tab_in;
         blank_ff <= blank_in;
      end
   end

   // effective grid size: zero acts as one, oversize acts as the maximum
   always_comb begin
      if (cols_ff == '0) begin
         cfg.cols_eff = ttcb_pkg::EFF_COLS_W'(1);
      end else if (ttcb_pkg::EFF_COLS_W'(cols_ff) > COLS_MAX) begin
         cfg.cols_eff = COLS_MAX;
      end else begin
         cfg.cols_eff = ttcb_pkg::EFF_COLS_W'(cols_ff);
      end
      if (rows_ff == '0) begin
         cfg.rows_eff = ttcb_pkg::EFF_ROWS_W'(1);
      end else if (ttcb_pkg::EFF_ROWS_W'(rows_ff) > ROWS_MAX) begin
         cfg.rows_eff = ROWS_MAX;
      end else begin
         cfg.rows_eff = ttcb_pkg::EFF_ROWS_W'(rows_ff);
      end
      cfg.tab         = tab_ff;
      cfg.blank_style = blank_ff;
   end

   // sequencer: cursor, scroll offset, sweeps and the result registers
   ttcb_ctrl #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .STYLE_BITS (STYLE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .cfg         (cfg),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // cell store: character in the upper bits, style in the lower
   ttcb_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
